// File: hw/rtl/svpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpm_pkg
// Shared types and constants of the supply voltage peak monitor.
// ----------------------------------------------------------------------------
package svpm_pkg;

  localparam int VREF_W   = 12;
  localparam int MV_W     = 16;
  localparam int GAIN_W   = 16;
  localparam int FRAC_W   = 8;
  localparam int SMOOTH_W = MV_W + FRAC_W;
  localparam int PROD_W   = SMOOTH_W + GAIN_W;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;
  localparam int QDEPTH   = 2;

  localparam logic [VREF_W-1:0] VREF_RESET = 12'd1100;
  localparam logic [MV_W-1:0]   MIN_RESET  = 16'd0;
  localparam logic [GAIN_W-1:0] FALL_RESET = 16'd6554;
  localparam logic [GAIN_W-1:0] RISE_RESET = 16'd655;
  localparam logic [PROD_W-1:0] ROUND_HALF = 40'd32768;
  localparam logic [MV_W-1:0]   MV_MAX     = 16'hFFFF;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_START  = 2'd1,
    CMD_END    = 2'd2,
    CMD_PRESET = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_VREF = 2'd0,
    REG_MIN  = 2'd1,
    REG_FALL = 2'd2,
    REG_RISE = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_CHECK,
    ST_DIFF,
    ST_MUL,
    ST_APPLY,
    ST_DONE
  } state_t;

  // queue entry: decoded command and its one operand
  typedef struct packed {
    cmd_t            cmd;
    logic [MV_W-1:0] arg;
  } item_t;

  typedef struct packed {
    logic [VREF_W-1:0] vref_mv;
    logic [MV_W-1:0]   min_vcc_mv;
    logic [GAIN_W-1:0] fall_gain;
    logic [GAIN_W-1:0] rise_gain;
  } cfg_t;

endpackage

// File: hw/rtl/svpm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpm_front
// Input side: takes command transfers, picks the operand the command uses
// and pushes the decoded entry into the queue.
// ----------------------------------------------------------------------------
module svpm_front #(
  parameter int ADC_BITS = 10
) (
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   command,
  input  logic [ADC_BITS-1:0]          adc_sample,
  input  logic [svpm_pkg::MV_W-1:0]    preset_mv,
  input  logic                         q_full,
  output logic                         q_push,
  output svpm_pkg::item_t              q_item
);

  svpm_pkg::cmd_t cmd;

  assign cmd      = svpm_pkg::cmd_t'(command);
  // hold off transfers while in reset
  assign in_stall = q_full || rst;
  assign q_push   = in_valid && !q_full && !rst;

  always_comb begin
    q_item.cmd = cmd;
    case (cmd)
      svpm_pkg::CMD_PRESET: q_item.arg = preset_mv;
      svpm_pkg::CMD_SAMPLE: q_item.arg = svpm_pkg::MV_W'(adc_sample);
      default:              q_item.arg = '0;
    endcase
  end

endmodule

// File: hw/rtl/svpm_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpm_fifo
// Short queue of decoded commands between the front and the back.
// ----------------------------------------------------------------------------
module svpm_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  svpm_pkg::item_t  wr_item,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output svpm_pkg::item_t  rd_item
);

  localparam int PTR_W = $clog2(svpm_pkg::QDEPTH);
  localparam int CNT_W = $clog2(svpm_pkg::QDEPTH + 1);

  svpm_pkg::item_t  slots [svpm_pkg::QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(svpm_pkg::QDEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(svpm_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(svpm_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/svpm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpm_back
// Execution side: keeps the window peak, divides at window end, latches the
// low-supply fault, runs the smoothing filter and holds the result register.
// ----------------------------------------------------------------------------
module svpm_back #(
  parameter int ADC_BITS   = 10,
  parameter int FULL_SCALE = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  svpm_pkg::cfg_t               cfg,
  input  logic                         q_empty,
  input  svpm_pkg::item_t              q_item,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         window_done,
  output logic [svpm_pkg::MV_W-1:0]    vcc_mv,
  output logic [svpm_pkg::MV_W-1:0]    smoothed_mv,
  output logic [ADC_BITS-1:0]          peak_reading,
  output logic                         fault
);

  localparam int NUM_W = svpm_pkg::VREF_W + $clog2(FULL_SCALE + 1);
  localparam int CNT_W = $clog2(NUM_W);
  localparam int SW    = svpm_pkg::SMOOTH_W;

  svpm_pkg::state_t          state;
  svpm_pkg::state_t          state_next;
  svpm_pkg::item_t           cur;
  logic [ADC_BITS-1:0]       peak;
  logic [SW-1:0]             smoothed;
  logic                      low_fault;

  logic [NUM_W-1:0]          num;
  logic [ADC_BITS-1:0]       rem;
  logic [CNT_W-1:0]          cnt;
  logic [ADC_BITS:0]         rem_sh;
  logic                      rem_ge;
  logic [svpm_pkg::MV_W-1:0] vcc_sat;
  logic [svpm_pkg::MV_W-1:0] vcc;

  logic [SW-1:0]             target;
  logic                      falling;
  logic [SW-1:0]             diff;
  logic [svpm_pkg::GAIN_W-1:0] gain;
  logic [svpm_pkg::PROD_W-1:0] prod;
  logic [svpm_pkg::PROD_W-1:0] prod_rnd;
  logic [SW-1:0]             step;

  logic                      load_out;

  // restoring divider, one quotient bit per cycle
  assign rem_sh  = {rem, num[NUM_W-1]};
  assign rem_ge  = (rem_sh >= {1'b0, peak});
  assign vcc_sat = (|num[NUM_W-1:svpm_pkg::MV_W]) ? svpm_pkg::MV_MAX
                                                   : num[svpm_pkg::MV_W-1:0];
  assign target  = {vcc, {svpm_pkg::FRAC_W{1'b0}}};
  assign prod_rnd = prod + svpm_pkg::ROUND_HALF;
  assign step    = prod_rnd[svpm_pkg::GAIN_W +: SW];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= svpm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    load_out   = 1'b0;
    case (state)
      svpm_pkg::ST_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = svpm_pkg::ST_EXEC;
        end
      end
      svpm_pkg::ST_EXEC: begin
        if (cur.cmd == svpm_pkg::CMD_END) begin
          state_next = (peak == '0) ? svpm_pkg::ST_CHECK : svpm_pkg::ST_DIV;
        end else begin
          state_next = svpm_pkg::ST_DONE;
        end
      end
      svpm_pkg::ST_DIV: begin
        if (cnt == '0) begin
          state_next = svpm_pkg::ST_CHECK;
        end
      end
      svpm_pkg::ST_CHECK: begin
        if (vcc_sat <= cfg.min_vcc_mv || low_fault) begin
          state_next = svpm_pkg::ST_DONE;
        end else begin
          state_next = svpm_pkg::ST_DIFF;
        end
      end
      svpm_pkg::ST_DIFF:  state_next = svpm_pkg::ST_MUL;
      svpm_pkg::ST_MUL:   state_next = svpm_pkg::ST_APPLY;
      svpm_pkg::ST_APPLY: state_next = svpm_pkg::ST_DONE;
      svpm_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = svpm_pkg::ST_IDLE;
        end
      end
      default: state_next = svpm_pkg::ST_IDLE;
    endcase
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      peak      <= '0;
      smoothed  <= '0;
      low_fault <= 1'b0;
    end else begin
      case (state)
        svpm_pkg::ST_EXEC: begin
          case (cur.cmd)
            svpm_pkg::CMD_SAMPLE: begin
              if (cur.arg[ADC_BITS-1:0] > peak) begin
                peak <= cur.arg[ADC_BITS-1:0];
              end
            end
            svpm_pkg::CMD_START:  peak <= '0;
            svpm_pkg::CMD_PRESET: smoothed <= {cur.arg, {svpm_pkg::FRAC_W{1'b0}}};
            default: ;
          endcase
        end
        svpm_pkg::ST_CHECK: begin
          if (vcc_sat <= cfg.min_vcc_mv) begin
            low_fault <= 1'b1;
          end
        end
        svpm_pkg::ST_APPLY: begin
          smoothed <= falling ? smoothed - step : smoothed + step;
        end
        default: ;
      endcase
    end
  end

  // working registers of the divider and filter
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_item;
    end
    case (state)
      svpm_pkg::ST_EXEC: begin
        num <= (peak == '0) ? '0
                            : NUM_W'(cfg.vref_mv) * NUM_W'(FULL_SCALE);
        rem <= '0;
        cnt <= CNT_W'(NUM_W - 1);
      end
      svpm_pkg::ST_DIV: begin
        num <= {num[NUM_W-2:0], rem_ge};
        rem <= rem_ge ? ADC_BITS'(rem_sh - {1'b0, peak}) : rem_sh[ADC_BITS-1:0];
        cnt <= cnt - 1'b1;
      end
      svpm_pkg::ST_CHECK: vcc <= vcc_sat;
      svpm_pkg::ST_DIFF: begin
        falling <= (target < smoothed);
        diff    <= (target < smoothed) ? smoothed - target : target - smoothed;
        gain    <= (target < smoothed) ? cfg.fall_gain : cfg.rise_gain;
      end
      svpm_pkg::ST_MUL: prod <= svpm_pkg::PROD_W'(diff) * svpm_pkg::PROD_W'(gain);
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      window_done  <= (cur.cmd == svpm_pkg::CMD_END);
      vcc_mv       <= (cur.cmd == svpm_pkg::CMD_END) ? vcc : '0;
      smoothed_mv  <= smoothed[SW-1:svpm_pkg::FRAC_W];
      peak_reading <= peak;
      fault        <= low_fault;
    end
  end

endmodule

// File: hw/rtl/supply_voltage_peak_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// supply_voltage_peak_monitor
// Supply monitor built from the window peak of reference readings.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries command, adc_sample, preset_mv;
// a transfer happens when in_valid is high and in_stall low. Every command
// gives exactly one result on the output channel (out_valid / out_stall).
// The front decodes commands into a two-entry queue; the back runs them one
// at a time. An end window runs the restoring divider, which produces one
// quotient bit per cycle, NUM_W = 12 + clog2(FULL_SCALE + 1) bits in all. An
// end window with a zero peak skips the divider, and one that finds the
// supply at or below the minimum, or the fault already set, skips smoothing.
// While the receiver stalls, the result register holds its value, the back
// finishes the next command and waits, and once the queue fills in_stall
// rises. Synchronous reset empties the queue, drops out_valid, clears peak,
// smoothed value and fault, and restores the register defaults; in_stall
// stays high during reset.
// Registers over APB at byte addresses 0, 4, 8, 12: vref_mv, min_vcc_mv,
// fall_gain, rise_gain; write them only while the block is idle.
// ----------------------------------------------------------------------------
module supply_voltage_peak_monitor #(
  parameter int ADC_BITS   = 10,
  parameter int FULL_SCALE = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    command,
  input  logic [ADC_BITS-1:0]           adc_sample,
  input  logic [svpm_pkg::MV_W-1:0]     preset_mv,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          window_done,
  output logic [svpm_pkg::MV_W-1:0]     vcc_mv,
  output logic [svpm_pkg::MV_W-1:0]     smoothed_mv,
  output logic [ADC_BITS-1:0]           peak_reading,
  output logic                          fault,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [svpm_pkg::ADDR_W-1:0]   paddr,
  input  logic [svpm_pkg::DATA_W-1:0]   pwdata,
  output logic [svpm_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  svpm_pkg::cfg_t     cfg;
  svpm_pkg::reg_idx_t reg_idx;
  svpm_pkg::item_t    push_item;
  svpm_pkg::item_t    pop_item;
  logic               q_push;
  logic               q_full;
  logic               q_pop;
  logic               q_empty;
  logic               wr_en;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = svpm_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.vref_mv    <= svpm_pkg::VREF_RESET;
      cfg.min_vcc_mv <= svpm_pkg::MIN_RESET;
      cfg.fall_gain  <= svpm_pkg::FALL_RESET;
      cfg.rise_gain  <= svpm_pkg::RISE_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        svpm_pkg::REG_VREF: cfg.vref_mv    <= pwdata[svpm_pkg::VREF_W-1:0];
        svpm_pkg::REG_MIN:  cfg.min_vcc_mv <= pwdata[svpm_pkg::MV_W-1:0];
        svpm_pkg::REG_FALL: cfg.fall_gain  <= pwdata[svpm_pkg::GAIN_W-1:0];
        svpm_pkg::REG_RISE: cfg.rise_gain  <= pwdata[svpm_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      svpm_pkg::REG_VREF: prdata = svpm_pkg::DATA_W'(cfg.vref_mv);
      svpm_pkg::REG_MIN:  prdata = svpm_pkg::DATA_W'(cfg.min_vcc_mv);
      svpm_pkg::REG_FALL: prdata = svpm_pkg::DATA_W'(cfg.fall_gain);
      svpm_pkg::REG_RISE: prdata = svpm_pkg::DATA_W'(cfg.rise_gain);
      default:            prdata = '0;
    endcase
  end

  svpm_front #(
    .ADC_BITS (ADC_BITS)
  ) u_front (
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .adc_sample (adc_sample),
    .preset_mv  (preset_mv),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_item     (push_item)
  );

  svpm_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_item (push_item),
    .full    (q_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_item (pop_item)
  );

  svpm_back #(
    .ADC_BITS   (ADC_BITS),
    .FULL_SCALE (FULL_SCALE)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_empty      (q_empty),
    .q_item       (pop_item),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .window_done  (window_done),
    .vcc_mv       (vcc_mv),
    .smoothed_mv  (smoothed_mv),
    .peak_reading (peak_reading),
    .fault        (fault)
  );

endmodule

// File: hw/rtl/svpm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpm_checker
// Port-level checks of the supply voltage peak monitor result channel.
// ----------------------------------------------------------------------------
module svpm_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic                       window_done,
  input logic [svpm_pkg::MV_W-1:0]  vcc_mv,
  input logic [svpm_pkg::MV_W-1:0]  smoothed_mv,
  input logic                       fault
);

  // hold a stalled transfer
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(vcc_mv) && $stable(smoothed_mv))
    else $error("stalled result changed");

  // fault is sticky until reset
  a_fault_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && fault |=> fault)
    else $error("fault cleared without reset");

  a_vcc_only_at_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !window_done |-> vcc_mv == '0)
    else $error("supply value outside window end");

  // a zero supply can never exceed the minimum
  a_zero_faults: assert property (@(posedge clk) disable iff (rst)
    out_valid && window_done && vcc_mv == '0 |-> fault)
    else $error("zero supply without fault");

endmodule

bind supply_voltage_peak_monitor svpm_checker u_svpm_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .window_done (window_done),
  .vcc_mv      (vcc_mv),
  .smoothed_mv (smoothed_mv),
  .fault       (fault)
);

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the supply voltage peak monitor. Commands go in
// over the valid/stall input channel. A model of the peak, divider,
// smoothing and fault logic predicts every result, and each result that
// comes out is compared field by field in arrival order. The registers are
// swept over several settings through the APB port, including the extremes.
// Both channels idle at random, and one long output hold-off fills the block.
// ----------------------------------------------------------------------------
module testbench;

  localparam int ADC_W         = 10;
  localparam int FULL_SCALE    = 1024;
  localparam int HOLD_LEN      = 400;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 1000000;

  localparam int MV_W     = svpm_pkg::MV_W;
  localparam int SMOOTH_W = svpm_pkg::SMOOTH_W;
  localparam int FRAC_W   = svpm_pkg::FRAC_W;
  localparam int VREF_W   = svpm_pkg::VREF_W;
  localparam int GAIN_W   = svpm_pkg::GAIN_W;
  localparam int ADDR_W   = svpm_pkg::ADDR_W;
  localparam int DATA_W   = svpm_pkg::DATA_W;

  typedef struct packed {
    logic             done;
    logic [MV_W-1:0]  vcc;
    logic [MV_W-1:0]  smooth;
    logic [ADC_W-1:0] peak;
    logic             flt;
  } reading_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [1:0]          command;
  logic [ADC_W-1:0]    adc_sample;
  logic [MV_W-1:0]     preset_mv;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                window_done;
  logic [MV_W-1:0]     vcc_mv;
  logic [MV_W-1:0]     smoothed_mv;
  logic [ADC_W-1:0]    peak_reading;
  logic                fault;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // monitor model state and register copies
  logic [ADC_W-1:0]    peak_r   = '0;
  logic [SMOOTH_W-1:0] smooth_r = '0;
  logic                fault_r  = 1'b0;
  logic [VREF_W-1:0]   vref_r   = 12'd1100;
  logic [MV_W-1:0]     min_r    = 16'd0;
  logic [GAIN_W-1:0]   fall_r   = 16'd6554;
  logic [GAIN_W-1:0]   rise_r   = 16'd655;

  reading_t pending_readings[$];
  reading_t got_r;
  reading_t want_r;
  int       mismatches = 0;
  int       items_sent = 0;
  logic     quiet      = 1'b0;
  logic     hold_req   = 1'b0;
  int       hold_left  = 0;
  int       burst_left = 0;

  supply_voltage_peak_monitor #(
    .ADC_BITS  (ADC_W),
    .FULL_SCALE(FULL_SCALE)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .adc_sample  (adc_sample),
    .preset_mv   (preset_mv),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .window_done (window_done),
    .vcc_mv      (vcc_mv),
    .smoothed_mv (smoothed_mv),
    .peak_reading(peak_reading),
    .fault       (fault),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [MV_W-1:0] supply_of(logic [ADC_W-1:0] pk);
    logic [31:0] q;
    if (pk == '0) return '0;
    q = (32'(vref_r) * FULL_SCALE) / 32'(pk);
    return (q > 32'hFFFF) ? 16'hFFFF : q[MV_W-1:0];
  endfunction

  function automatic void smooth_toward(logic [MV_W-1:0] v);
    logic [SMOOTH_W-1:0] target;
    logic [SMOOTH_W-1:0] d;
    logic [GAIN_W-1:0]   gain;
    logic [63:0]         prod;
    logic                falling;
    target  = {v, 8'h00};
    falling = target < smooth_r;
    d       = falling ? smooth_r - target : target - smooth_r;
    gain    = falling ? fall_r : rise_r;
    prod    = 64'(d) * 64'(gain) + 64'd32768;
    if (falling) smooth_r = smooth_r - prod[39:16];
    else smooth_r = smooth_r + prod[39:16];
  endfunction

  function automatic reading_t monitor_step(svpm_pkg::cmd_t c, logic [ADC_W-1:0] adc,
                                            logic [MV_W-1:0] pre);
    reading_t r;
    r.done = 1'b0;
    r.vcc  = '0;
    case (c)
      svpm_pkg::CMD_SAMPLE: if (adc > peak_r) peak_r = adc;
      svpm_pkg::CMD_START:  peak_r = '0;
      svpm_pkg::CMD_END: begin
        r.done = 1'b1;
        r.vcc  = supply_of(peak_r);
        if (r.vcc <= min_r) fault_r = 1'b1;
        else if (!fault_r) smooth_toward(r.vcc);
      end
      default:    smooth_r = {pre, 8'h00};
    endcase
    r.smooth = smooth_r[SMOOTH_W-1:FRAC_W];
    r.peak   = peak_r;
    r.flt    = fault_r;
    return r;
  endfunction

  function automatic logic [ADC_W-1:0] rand_adc();
    case ($urandom_range(0, 9))
      0:       return ADC_W'($urandom_range(1, 15));
      1:       return ADC_W'($urandom_range(1000, 1023));
      default: return ADC_W'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    // keep the log short when everything breaks
    if (mismatches < 100)
      $display("%0t: %s got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic send_item(svpm_pkg::cmd_t c, logic [ADC_W-1:0] adc,
                           logic [MV_W-1:0] pre);
    in_valid   <= 1'b1;
    command    <= c;
    adc_sample <= adc;
    preset_mv  <= pre;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_readings.push_back(monitor_step(c, adc, pre));
    items_sent++;
    if (!quiet && $urandom_range(0, 99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // Before the fault phase, turn an end window that would latch the fault
  // into a sample so the window keeps going.
  task automatic send_guarded(svpm_pkg::cmd_t c, logic [ADC_W-1:0] adc,
                              logic [MV_W-1:0] pre, bit safe);
    if (safe && c == svpm_pkg::CMD_END && supply_of(peak_r) <= min_r)
      c = svpm_pkg::CMD_SAMPLE;
    send_item(c, adc, pre);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(svpm_pkg::reg_idx_t idx, logic [DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      svpm_pkg::REG_VREF: vref_r = val[VREF_W-1:0];
      svpm_pkg::REG_MIN:  min_r  = val[MV_W-1:0];
      svpm_pkg::REG_FALL: fall_r = val[GAIN_W-1:0];
      svpm_pkg::REG_RISE: rise_r = val[GAIN_W-1:0];
      default: ;
    endcase
  endtask

  // upper data bits carry junk; only the field width is kept
  task automatic apply_config(logic [VREF_W-1:0] v, logic [MV_W-1:0] m,
                              logic [GAIN_W-1:0] f, logic [GAIN_W-1:0] r);
    write_reg(svpm_pkg::REG_VREF, ($urandom() & 32'hFFFF_F000) | 32'(v));
    write_reg(svpm_pkg::REG_MIN,  ($urandom() & 32'hFFFF_0000) | 32'(m));
    write_reg(svpm_pkg::REG_FALL, ($urandom() & 32'hFFFF_0000) | 32'(f));
    write_reg(svpm_pkg::REG_RISE, ($urandom() & 32'hFFFF_0000) | 32'(r));
  endtask

  // Mostly whole windows with random readings, the rest random commands.
  task automatic run_random(int n, bit safe);
    int target;
    int k;
    target = items_sent + n;
    while (items_sent < target) begin
      if ($urandom_range(0, 99) < 15) begin
        send_guarded(svpm_pkg::cmd_t'($urandom_range(0, 3)), ADC_W'($urandom),
                     MV_W'($urandom), safe);
      end else begin
        send_item(svpm_pkg::CMD_START, ADC_W'($urandom), MV_W'($urandom));
        k = $urandom_range(1, 8);
        repeat (k) send_item(svpm_pkg::CMD_SAMPLE, rand_adc(), MV_W'($urandom));
        if ($urandom_range(0, 9) == 0)
          send_item(svpm_pkg::CMD_PRESET, ADC_W'($urandom), MV_W'($urandom));
        send_guarded(svpm_pkg::CMD_END, ADC_W'($urandom), MV_W'($urandom), safe);
      end
    end
  endtask

  task automatic test_directed();
    send_item(svpm_pkg::CMD_START,  10'd0,     16'd0);
    send_item(svpm_pkg::CMD_SAMPLE, 10'd0,     16'hFFFF);
    send_item(svpm_pkg::CMD_SAMPLE, 10'h3FF,   16'd0);
    send_item(svpm_pkg::CMD_SAMPLE, 10'h200,   16'd0);
    send_item(svpm_pkg::CMD_END,    10'd0,     16'd0);
    send_item(svpm_pkg::CMD_PRESET, 10'h3FF,   16'hFFFF);
    send_item(svpm_pkg::CMD_END,    10'd0,     16'd0);
    send_item(svpm_pkg::CMD_START,  10'h3FF,   16'hFFFF);
    send_item(svpm_pkg::CMD_SAMPLE, 10'h2AA,   16'h5555);
    send_item(svpm_pkg::CMD_SAMPLE, 10'h155,   16'hAAAA);
    send_item(svpm_pkg::CMD_END,    10'd0,     16'd0);
    // a peak of one overflows the quotient
    send_item(svpm_pkg::CMD_START,  10'd0,     16'd0);
    send_item(svpm_pkg::CMD_SAMPLE, 10'd1,     16'd0);
    send_item(svpm_pkg::CMD_END,    10'd0,     16'd0);
    send_item(svpm_pkg::CMD_PRESET, 10'd0,     16'd0);
  endtask

  task automatic test_config_sweep();
    int unsigned v;
    for (int i = 0; i < 6; i++) begin
      wait_idle();
      case (i)
        0: apply_config(12'd1100, 16'd0,    16'd6554,  16'd655);
        1: apply_config(12'd4095, 16'd4094, 16'hFFFF,  16'hFFFF);
        2: apply_config(12'd1,    16'd0,    16'd0,     16'd0);
        3: apply_config(12'd2048, 16'd1000, 16'd32768, 16'd1);
        default: begin
          // minimum below the reference keeps the fault clear
          v = $urandom_range(1, 4095);
          apply_config(VREF_W'(v), MV_W'($urandom_range(0, v - 1)),
                       GAIN_W'($urandom), GAIN_W'($urandom));
        end
      endcase
      run_random(240, 1'b1);
    end
  endtask

  task automatic test_backpressure();
    wait_idle();
    hold_req <= 1'b1;
    run_random(60, 1'b1);
  endtask

  task automatic test_fault_latch();
    wait_idle();
    apply_config(12'd1000, 16'd1999, 16'd6554, 16'd655);
    // 1000 * 1024 / 512 = 2000, one above the minimum
    send_item(svpm_pkg::CMD_START,  10'd0,   16'd0);
    send_item(svpm_pkg::CMD_SAMPLE, 10'd512, 16'd0);
    send_item(svpm_pkg::CMD_END,    10'd0,   16'd0);
    wait_idle();
    write_reg(svpm_pkg::REG_MIN, 32'd2000);
    // equal to the minimum latches the fault
    send_item(svpm_pkg::CMD_START,  10'd0,   16'd0);
    send_item(svpm_pkg::CMD_SAMPLE, 10'd512, 16'd0);
    send_item(svpm_pkg::CMD_END,    10'd0,   16'd0);
    // zero peak, then readings that no longer move the smoothed value
    send_item(svpm_pkg::CMD_START,  10'd0,   16'd0);
    send_item(svpm_pkg::CMD_END,    10'd0,   16'd0);
    send_item(svpm_pkg::CMD_SAMPLE, 10'd700, 16'd0);
    send_item(svpm_pkg::CMD_END,    10'd0,   16'd0);
    send_item(svpm_pkg::CMD_PRESET, 10'd0,   16'h1234);
    run_random(150, 1'b0);
    wait_idle();
    apply_config(12'd0, 16'hFFFF, 16'hFFFF, 16'd0);
    run_random(100, 1'b0);
    wait_idle();
    quiet <= 1'b1;
    apply_config(12'd4095, 16'd0, 16'd0, 16'hFFFF);
    run_random(150, 1'b0);
  endtask

  // output stall: long hold-off on request, else random bursts
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_req) begin
      hold_req  <= 1'b0;
      hold_left = HOLD_LEN - 1;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (burst_left > 0) begin
      burst_left--;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 99) < 10) begin
      burst_left = $urandom_range(0, 13);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      got_r = '{window_done, vcc_mv, smoothed_mv, peak_reading, fault};
      if (pending_readings.size() == 0) begin
        report_mismatch("unexpected result, vcc_mv", got_r.vcc, 0);
      end else begin
        want_r = pending_readings.pop_front();
        if (got_r.done !== want_r.done)
          report_mismatch("window_done", got_r.done, want_r.done);
        if (got_r.vcc !== want_r.vcc)
          report_mismatch("vcc_mv", got_r.vcc, want_r.vcc);
        if (got_r.smooth !== want_r.smooth)
          report_mismatch("smoothed_mv", got_r.smooth, want_r.smooth);
        if (got_r.peak !== want_r.peak)
          report_mismatch("peak_reading", got_r.peak, want_r.peak);
        if (got_r.flt !== want_r.flt)
          report_mismatch("fault", got_r.flt, want_r.flt);
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("supply_voltage_peak_monitor test failed");
    $finish;
  end

  initial begin
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    command    <= svpm_pkg::CMD_SAMPLE;
    adc_sample <= '0;
    preset_mv  <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_config_sweep();
    test_backpressure();
    test_fault_latch();
    wait_idle();
    if (mismatches == 0) $display("supply_voltage_peak_monitor test passed");
    else $display("supply_voltage_peak_monitor test failed");
    $finish;
  end

endmodule
